// ===== rtl/cdd_pkg.sv =====
// Shared types, constants and helper functions of the countdown digit display.
package cdd_pkg;

	localparam int DIGIT_COUNT = 7;
	localparam int TIME_DIGITS = 5;
	localparam int TIME_W = 30;
	localparam int STEP_W = 20;
	localparam int DIGIT_W = 4;
	localparam int INDEX_W = 3;
	localparam int DELTA_W = 14;
	localparam int DELTA_SHIFT = 9;
	localparam int OP_W = 2;
	localparam int LFSR_W = 16;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 24;

	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
	localparam logic [OP_W-1:0] OP_MENU = 2'd2;

	localparam logic [TIME_W-1:0] TIME_CAP = 30'd599999999;
	localparam logic [STEP_W-1:0] STEP_RESET = 20'd16667;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

	localparam logic [TIME_W-1:0] DIV_TABLE [TIME_DIGITS] = '{
		30'd60000000, 30'd10000000, 30'd1000000, 30'd100000, 30'd10000
	};

	localparam logic [DIGIT_W-1:0] MENU_DIGITS [DIGIT_COUNT] = '{
		4'd1, 4'd5, 4'd9, 4'd5, 4'd0, 4'd0, 4'd0
	};

	typedef struct packed {
		logic load;
		logic show_menu;
		logic set_menu;
		logic tick;
		logic dig;
		logic fill;
		logic emit;
	} cdd_cmd_t;

	typedef struct packed {
		logic menu;
		logic dig_done;
		logic any_chg;
		logic one_chg;
		logic out_free;
	} cdd_sts_t;

	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
		logic [LFSR_W-1:0] n;
		n = s >> 1;
		if (s[0]) begin
			n = n ^ LFSR_MASK;
		end
		return n;
	endfunction

	// Remainder by ten through a reciprocal multiply, exact for all 16-bit values.
	function automatic logic [DIGIT_W-1:0] mod_ten(input logic [LFSR_W-1:0] x);
		logic [33:0] prod;
		logic [LFSR_W-1:0] q;
		logic [LFSR_W-1:0] r;
		prod = 34'(x) * 34'd52429;
		q = LFSR_W'(prod >> 19);
		r = x - LFSR_W'({q, 3'b000} + {q, 1'b0});
		return r[DIGIT_W-1:0];
	endfunction

endpackage

// ===== rtl/cdd_ctrl.sv =====
// Controller state machine that sequences load, digit split, filler draw and result transfers.
module cdd_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [cdd_pkg::OP_W-1:0] in_op,
	output logic                     in_ready,
	input  cdd_pkg::cdd_sts_t        sts,
	output cdd_pkg::cdd_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIG  = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_op)
						cdd_pkg::OP_LOAD: begin
							cmd.load = 1'b1;
						end
						cdd_pkg::OP_MENU: begin
							cmd.show_menu = 1'b1;
							cmd.set_menu = 1'b1;
							state_d = ST_EMIT;
						end
						cdd_pkg::OP_TICK: begin
							if (sts.menu) begin
								cmd.show_menu = 1'b1;
								state_d = ST_EMIT;
							end else begin
								cmd.tick = 1'b1;
								state_d = ST_DIG;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DIG: begin
				cmd.dig = 1'b1;
				if (sts.dig_done) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.any_chg) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.one_chg) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/cdd_dp.sv =====
// Datapath with the time, digit registers, digit splitter, random filler and output register.
module cdd_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [cdd_pkg::STEP_W-1:0]     cfg_data,
	input  logic [cdd_pkg::TIME_W-1:0]     load_time,
	input  cdd_pkg::cdd_cmd_t              cmd,
	output cdd_pkg::cdd_sts_t              sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cdd_pkg::INDEX_W-1:0]    out_index,
	output logic [cdd_pkg::DIGIT_W-1:0]    out_value,
	output logic [cdd_pkg::DELTA_W-1:0]    out_delta,
	output logic                           out_last
);

	localparam int DW = cdd_pkg::DIGIT_W;
	localparam int DC = cdd_pkg::DIGIT_COUNT;
	localparam int TW = cdd_pkg::TIME_W;

	logic [cdd_pkg::STEP_W-1:0]  step_q;
	logic [TW-1:0]               time_q;
	logic                        menu_q;
	logic [DW-1:0]               shown_q [DC];
	logic [DW-1:0]               new_q [DC];
	logic [cdd_pkg::LFSR_W-1:0]  lfsr_q;
	logic [TW-1:0]               rem_q;
	logic [cdd_pkg::INDEX_W-1:0] cnt_q;

	logic [cdd_pkg::INDEX_W-1:0] out_index_q;
	logic [DW-1:0]               out_value_q;
	logic [cdd_pkg::DELTA_W-1:0] out_delta_q;
	logic                        out_last_q;
	logic                        out_valid_q;

	logic [TW-1:0]               time_dec;
	logic [TW-1:0]               load_cap;
	logic [TW-1:0]               mult [10];
	logic [9:1]                  ge;
	logic [DW-1:0]               quot;
	logic [cdd_pkg::LFSR_W-1:0]  draw_a;
	logic [cdd_pkg::LFSR_W-1:0]  draw_b;
	logic [DC-1:0]               chg;
	logic [cdd_pkg::INDEX_W-1:0] sel;
	logic [DW:0]                 diff;

	assign time_dec = (time_q > TW'(step_q)) ? time_q - TW'(step_q) : '0;
	assign load_cap = (load_time > cdd_pkg::TIME_CAP) ? cdd_pkg::TIME_CAP : load_time;

	for (genvar m = 0; m < 10; m++) begin : g_mult
		assign mult[m] = TW'(cdd_pkg::DIV_TABLE[cnt_q] * TW'(m));
	end

	for (genvar g = 1; g < 10; g++) begin : g_ge
		assign ge[g] = (rem_q >= mult[g]);
	end

	assign quot = DW'($countones(ge));
	assign draw_a = cdd_pkg::lfsr_next(lfsr_q);
	assign draw_b = cdd_pkg::lfsr_next(draw_a);

	for (genvar i = 0; i < DC; i++) begin : g_chg
		assign chg[i] = (new_q[i] != shown_q[i]);
	end

	always_comb begin
		sel = '0;
		for (int i = DC - 1; i >= 0; i--) begin
			if (chg[i]) begin
				sel = cdd_pkg::INDEX_W'(i);
			end
		end
	end

	assign diff = {1'b0, new_q[sel]} - {1'b0, shown_q[sel]};

	assign sts.menu = menu_q;
	assign sts.dig_done = (cnt_q == cdd_pkg::INDEX_W'(cdd_pkg::TIME_DIGITS - 1));
	assign sts.any_chg = |chg;
	assign sts.one_chg = ((chg & (chg - DC'(1))) == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= cdd_pkg::STEP_RESET;
			time_q <= '0;
			menu_q <= 1'b0;
			lfsr_q <= cdd_pkg::LFSR_SEED;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DC; i++) begin
				shown_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				step_q <= cfg_data;
			end
			if (cmd.load) begin
				time_q <= load_cap;
				menu_q <= 1'b0;
				for (int i = 0; i < DC; i++) begin
					shown_q[i] <= '0;
				end
			end
			if (cmd.set_menu) begin
				menu_q <= 1'b1;
			end
			if (cmd.tick) begin
				time_q <= time_dec;
				cnt_q <= '0;
			end
			if (cmd.dig) begin
				cnt_q <= cnt_q + cdd_pkg::INDEX_W'(1);
			end
			if (cmd.fill && rem_q != '0) begin
				lfsr_q <= draw_b;
			end
			if (cmd.emit) begin
				shown_q[sel] <= new_q[sel];
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			rem_q <= time_dec;
		end
		if (cmd.dig) begin
			new_q[cnt_q] <= quot;
			rem_q <= rem_q - mult[quot];
		end
		if (cmd.fill) begin
			if (rem_q != '0) begin
				new_q[5] <= cdd_pkg::mod_ten(draw_a);
				new_q[6] <= cdd_pkg::mod_ten(draw_b);
			end else begin
				new_q[5] <= '0;
				new_q[6] <= '0;
			end
		end
		if (cmd.show_menu) begin
			for (int i = 0; i < DC; i++) begin
				new_q[i] <= cdd_pkg::MENU_DIGITS[i];
			end
		end
		if (cmd.emit) begin
			out_index_q <= sel;
			out_value_q <= new_q[sel];
			out_delta_q <= {diff, {cdd_pkg::DELTA_SHIFT{1'b0}}};
			out_last_q <= sts.one_chg;
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign out_delta = out_delta_q;
	assign out_last = out_last_q;

endmodule

// ===== rtl/countdown_digit_display.sv =====
// Top level of the countdown timer with decimal digit display.
//
// Channel  Direction  Handshake                     Content
// s_axis   in         s_axis_tvalid/s_axis_tready   tuser operation, tdata load_time
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata index/value/delta, tlast
// cfg      in         cfg_valid/cfg_ready           cfg_data tick_step
//
// A load returns no result. A menu item sends one transfer per changed digit.
// A tick outside the menu splits the time into its digits, draws the filler digits and sends one transfer
// per changed digit: the digit splitter resolves one decimal digit per cycle and the single output
// register sends one transfer per cycle while the output is not stalled.
// Reset is asynchronous and active low; the step returns to 16667 us and the LFSR to its seed.
// A stalled output holds the result and pauses the emit sequence; input is taken only when idle.
module countdown_digit_display (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [cdd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [29:0] load_time
	input  logic [cdd_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] operation
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [cdd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [2:0] index, [6:3] value, [20:7] delta
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cdd_pkg::STEP_W-1:0]        cfg_data
);

	cdd_pkg::cdd_cmd_t cmd;
	cdd_pkg::cdd_sts_t sts;

	logic [cdd_pkg::INDEX_W-1:0] out_index;
	logic [cdd_pkg::DIGIT_W-1:0] out_value;
	logic [cdd_pkg::DELTA_W-1:0] out_delta;

	assign cfg_ready = 1'b1;

	cdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cdd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.load_time (s_axis_tdata[cdd_pkg::TIME_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_index (out_index),
		.out_value (out_value),
		.out_delta (out_delta),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, out_delta, out_value, out_index};

endmodule

// ===== rtl/cdd_chk.sv =====
// Port-level assertion checker for the countdown digit display, bound to the top level.
module cdd_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [cdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic [cdd_pkg::OP_W-1:0]       s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [cdd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [cdd_pkg::STEP_W-1:0]     cfg_data
);

	// A stalled result keeps its contents until the transfer happens.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output result changed while stalled");

	// Every result names a real digit with a decimal value.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd7) &&
			(m_axis_tdata[6:3] <= 4'd9))
		else $error("digit index or value out of range");

	// A reported change is a nonzero whole multiple of 512.
	a_out_delta: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:7] == 9'd0) && (m_axis_tdata[20:16] != 5'd0))
		else $error("offset delta is not a nonzero multiple of 512");

	// A load never starts a new result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == cdd_pkg::OP_LOAD) |=>
			!$rose(m_axis_tvalid))
		else $error("load produced a result");

endmodule

bind countdown_digit_display cdd_chk u_cdd_chk (.*);

// ===== verif/countdown_digit_display_chk.sv =====
// Checker for the countdown digit display: predicts digit changes and compares every result transfer.
module countdown_digit_display_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [cdd_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [29:0] load_time
	input  logic [cdd_pkg::OP_W-1:0]       s_axis_tuser,  // [1:0] operation
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [cdd_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [2:0] index, [6:3] value, [20:7] delta
	input  logic                           m_axis_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [cdd_pkg::STEP_W-1:0]     cfg_data,
	output int unsigned                    fail_count,
	output int unsigned                    pending
);

	localparam int DIGITS = 7;
	localparam logic [29:0] TIME_LIMIT = 30'd599999999;
	localparam logic [19:0] STEP_DEFAULT = 20'd16667;
	localparam logic [15:0] NOISE_SEED = 16'hACE1;
	localparam logic [15:0] NOISE_TAPS = 16'hB400;
	localparam logic [27:0] MENU_FACE = {4'd0, 4'd0, 4'd0, 4'd5, 4'd9, 4'd5, 4'd1};

	typedef struct packed {
		logic [2:0]  idx;
		logic [3:0]  val;
		logic [13:0] delta;
		logic        last;
	} digit_change_t;

	digit_change_t change_q [$];
	digit_change_t batch [DIGITS];
	int            batch_len;

	logic [29:0] t_left;
	logic        menu_on;
	logic [3:0]  shown [DIGITS];
	logic [15:0] noise;
	logic [19:0] step;

	function automatic logic [15:0] noise_advance(input logic [15:0] s);
		logic [15:0] nxt;
		nxt = s >> 1;
		if (s[0]) begin
			nxt = nxt ^ NOISE_TAPS;
		end
		return nxt;
	endfunction

	task automatic show_digit(input int idx, input logic [3:0] v);
		if (shown[idx] != v) begin
			batch[batch_len].idx = 3'(idx);
			batch[batch_len].val = v;
			batch[batch_len].delta = 14'((int'(v) - int'(shown[idx])) * 512);
			batch[batch_len].last = 1'b0;
			batch_len++;
			shown[idx] = v;
		end
	endtask

	task automatic apply_item(input logic [1:0] op, input logic [29:0] load_val);
		int unsigned rest;
		logic [3:0] fill_hi;
		logic [3:0] fill_lo;
		batch_len = 0;
		case (op)
			cdd_pkg::OP_LOAD: begin
				t_left = (load_val > TIME_LIMIT) ? TIME_LIMIT : load_val;
				menu_on = 1'b0;
				for (int i = 0; i < DIGITS; i++) begin
					shown[i] = 4'd0;
				end
			end
			cdd_pkg::OP_MENU: begin
				menu_on = 1'b1;
				for (int i = 0; i < DIGITS; i++) begin
					show_digit(i, MENU_FACE[4*i +: 4]);
				end
			end
			cdd_pkg::OP_TICK: begin
				if (menu_on) begin
					for (int i = 0; i < DIGITS; i++) begin
						show_digit(i, MENU_FACE[4*i +: 4]);
					end
				end else begin
					if (t_left != 30'd0) begin
						t_left = (t_left > 30'(step)) ? t_left - 30'(step) : 30'd0;
					end
					rest = t_left;
					show_digit(0, 4'(rest / 60000000));
					rest = rest % 60000000;
					show_digit(1, 4'(rest / 10000000));
					rest = rest % 10000000;
					show_digit(2, 4'(rest / 1000000));
					rest = rest % 1000000;
					show_digit(3, 4'(rest / 100000));
					rest = rest % 100000;
					show_digit(4, 4'(rest / 10000));
					rest = rest % 10000;
					if (rest != 0) begin
						noise = noise_advance(noise);
						fill_hi = 4'(noise % 16'd10);
						noise = noise_advance(noise);
						fill_lo = 4'(noise % 16'd10);
						show_digit(5, fill_hi);
						show_digit(6, fill_lo);
					end else begin
						show_digit(5, 4'd0);
						show_digit(6, 4'd0);
					end
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < batch_len; i++) begin
			batch[i].last = (i == batch_len - 1);
			change_q.push_back(batch[i]);
		end
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	task automatic check_result();
		digit_change_t got;
		digit_change_t want;
		got.idx = m_axis_tdata[2:0];
		got.val = m_axis_tdata[6:3];
		got.delta = m_axis_tdata[20:7];
		got.last = m_axis_tlast;
		if (change_q.size() == 0) begin
			note_failure($sformatf("Unexpected result transfer: index %0d value %0d delta %0d last %0b.",
				got.idx, got.val, $signed(got.delta), got.last));
		end else begin
			want = change_q.pop_front();
			if (got.idx != want.idx || got.val != want.val || got.delta != want.delta ||
					got.last != want.last) begin
				note_failure($sformatf({"Result mismatch: expected index %0d value %0d delta %0d ",
					"last %0b, got index %0d value %0d delta %0d last %0b."},
					want.idx, want.val, $signed(want.delta), want.last,
					got.idx, got.val, $signed(got.delta), got.last));
			end
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_left = 30'd0;
			menu_on = 1'b0;
			noise = NOISE_SEED;
			step = STEP_DEFAULT;
			for (int i = 0; i < DIGITS; i++) begin
				shown[i] = 4'd0;
			end
			change_q.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_result();
			end
			if (cfg_valid && cfg_ready) begin
				step = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_item(s_axis_tuser, s_axis_tdata[29:0]);
			end
			pending <= change_q.size();
		end
	end

endmodule

// ===== verif/countdown_digit_display_tb.sv =====
// Testbench top for the countdown digit display: clock, reset, stimulus and verdict.
module countdown_digit_display_tb;

	localparam logic [cdd_pkg::OP_W-1:0] OP_SPARE = 2'd3;
	localparam logic [29:0] TIME_LIMIT = 30'd599999999;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [cdd_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;  // [29:0] load_time
	logic [cdd_pkg::OP_W-1:0] s_axis_tuser = '0;       // [1:0] operation
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [cdd_pkg::OUT_DATA_W-1:0] m_axis_tdata;      // [2:0] index, [6:3] value, [20:7] delta
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cdd_pkg::STEP_W-1:0] cfg_data = '0;
	logic steady = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned quiet_cycles = 0;

	countdown_digit_display DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	countdown_digit_display_chk checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= 17);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("** countdown_digit_display: FAILED **");
			$finish;
		end
	end

	task automatic send_item(input logic [cdd_pkg::OP_W-1:0] op, input logic [29:0] load_val);
		while (!steady && $urandom_range(99) < 17) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {2'b00, load_val};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [cdd_pkg::STEP_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly a load followed by a burst of ticks, with menu items mixed in and some raw noise.
	task automatic run_phase(input int item_total);
		int done;
		int burst;
		logic [29:0] load_val;
		logic [cdd_pkg::OP_W-1:0] op;
		done = 0;
		while (done < item_total) begin
			if ($urandom_range(99) < 80) begin
				case ($urandom_range(3))
					0: load_val = 30'($urandom_range(599999999, 0));
					1: load_val = 30'($urandom);
					2: load_val = 30'($urandom_range(2000000, 0));
					default: load_val = 30'($urandom_range(59999, 0) * 10000);
				endcase
				send_item(cdd_pkg::OP_LOAD, load_val);
				done++;
				burst = $urandom_range(12, 1);
				repeat (burst) begin
					if ($urandom_range(19) == 0) begin
						send_item(cdd_pkg::OP_MENU, 30'($urandom));
					end else begin
						send_item(cdd_pkg::OP_TICK, 30'($urandom));
					end
					done++;
				end
			end else begin
				op = cdd_pkg::OP_W'($urandom_range(3));
				send_item(op, 30'($urandom));
				if (op != OP_SPARE) begin
					done++;
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_LOAD, TIME_LIMIT);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_TICK, 30'h3FFFFFFF);
		send_item(cdd_pkg::OP_LOAD, 30'h3FFFFFFF);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_MENU, 30'd0);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_MENU, 30'd0);
		send_item(OP_SPARE, 30'h2AAAAAAA);
		send_item(cdd_pkg::OP_LOAD, 30'd0);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_LOAD, 30'd10000);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_LOAD, 30'd60000000);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_LOAD, 30'd123456789);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_LOAD, 30'd20000);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_TICK, 30'd0);

		// A zero step leaves the time where it is but still refreshes the digits.
		drain();
		write_step(20'd0);
		send_item(cdd_pkg::OP_LOAD, 30'd300000000);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_LOAD, 30'd1234567);
		send_item(cdd_pkg::OP_TICK, 30'd0);
		send_item(cdd_pkg::OP_TICK, 30'd0);

		drain();
		write_step(20'd1);
		run_phase(70);

		drain();
		steady <= 1'b1;
		write_step(20'd1000000);
		run_phase(70);

		drain();
		steady <= 1'b0;
		write_step(20'hFFFFF);
		run_phase(60);

		repeat (3) begin
			drain();
			write_step(20'($urandom_range(1000000, 1)));
			run_phase(70);
		end

		drain();
		write_step(20'd16667);
		run_phase(60);

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("** countdown_digit_display: PASSED **");
		end else begin
			$display("** countdown_digit_display: FAILED **");
		end
		$finish;
	end

endmodule
